>>> rtl/fpa_pkg.sv
// Package for the fixed-point ALU: opcodes and widths.
package fpa_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 4;

  localparam logic [CMD_W-1:0] OP_ADD      = 4'd0;
  localparam logic [CMD_W-1:0] OP_SUB      = 4'd1;
  localparam logic [CMD_W-1:0] OP_MUL      = 4'd2;
  localparam logic [CMD_W-1:0] OP_DIV      = 4'd3;
  localparam logic [CMD_W-1:0] OP_INC      = 4'd4;
  localparam logic [CMD_W-1:0] OP_DEC      = 4'd5;
  localparam logic [CMD_W-1:0] OP_LT       = 4'd6;
  localparam logic [CMD_W-1:0] OP_GT       = 4'd7;
  localparam logic [CMD_W-1:0] OP_EQ       = 4'd8;
  localparam logic [CMD_W-1:0] OP_NE       = 4'd9;
  localparam logic [CMD_W-1:0] OP_GE       = 4'd10;
  localparam logic [CMD_W-1:0] OP_LE       = 4'd11;
  localparam logic [CMD_W-1:0] OP_MIN      = 4'd12;
  localparam logic [CMD_W-1:0] OP_MAX      = 4'd13;
  localparam logic [CMD_W-1:0] OP_TO_INT   = 4'd14;
  localparam logic [CMD_W-1:0] OP_FROM_INT = 4'd15;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [WORD_W-1:0] word_t;

endpackage

>>> rtl/fixed_point_alu.sv
// Fixed-point ALU top level: pipelined datapath with a bit-per-stage divider.
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, operand_a, operand_b.
//   Output channel (out_valid / out_stall) carries result_value,
//   compare_true and status, one result per input transaction, in order.
//   Every opcode takes the same path: three front stages (operand capture,
//   add/compare/multiply, then product select and divider load), then
//   32 + FRACTION_BITS divider stages that resolve one quotient bit each,
//   then the output register. Throughput is one transaction per cycle
//   while out_stall does not hold the pipeline.
//   The whole pipeline advances together: when out_valid is high and the
//   receiver asserts out_stall, every stage holds and in_stall goes high,
//   so nothing is dropped or repeated. Gaps between items travel as empty
//   stages.
//   Reset (rst, synchronous) clears every valid bit; payload registers are
//   not reset.
//   Division by zero gives result_value 0 and status 1; all arithmetic
//   wraps to 32 bits.
module fixed_point_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         cmd,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic               compare_true,
  output logic               status
);

  localparam int W  = fpa_pkg::WORD_W;
  localparam int DW = W + FRACTION_BITS;   // dividend width
  localparam int NS = DW;                  // divider stages

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: operand capture
  logic              s1_valid;
  fpa_pkg::cmd_t     s1_cmd;
  logic signed [W-1:0] s1_a, s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd <= cmd;
      s1_a   <= operand_a;
      s1_b   <= operand_b;
    end
  end

  // Stage 2: simple ops, compares, multiply, divider setup
  logic [W-1:0]        s2_res_next;
  logic                s2_cmp_next;
  logic signed [2*W-1:0] prod_next;
  logic [W-1:0]        mag_a, mag_b;

  always_comb begin
    s2_res_next = '0;
    s2_cmp_next = 1'b0;
    case (s1_cmd)
      fpa_pkg::OP_ADD:      s2_res_next = s1_a + s1_b;
      fpa_pkg::OP_SUB:      s2_res_next = s1_a - s1_b;
      fpa_pkg::OP_INC:      s2_res_next = s1_a + W'(1);
      fpa_pkg::OP_DEC:      s2_res_next = s1_a - W'(1);
      fpa_pkg::OP_LT:       s2_cmp_next = s1_a < s1_b;
      fpa_pkg::OP_GT:       s2_cmp_next = s1_a > s1_b;
      fpa_pkg::OP_EQ:       s2_cmp_next = s1_a == s1_b;
      fpa_pkg::OP_NE:       s2_cmp_next = s1_a != s1_b;
      fpa_pkg::OP_GE:       s2_cmp_next = s1_a >= s1_b;
      fpa_pkg::OP_LE:       s2_cmp_next = s1_a <= s1_b;
      fpa_pkg::OP_MIN:      s2_res_next = (s1_a > s1_b) ? s1_b : s1_a;
      fpa_pkg::OP_MAX:      s2_res_next = (s1_a < s1_b) ? s1_b : s1_a;
      fpa_pkg::OP_TO_INT:   s2_res_next = s1_a >>> FRACTION_BITS;
      fpa_pkg::OP_FROM_INT: s2_res_next = s1_a << FRACTION_BITS;
      default:              s2_res_next = '0;
    endcase
    prod_next = s1_a * s1_b;
    mag_a = s1_a[W-1] ? (~s1_a + W'(1)) : s1_a;
    mag_b = s1_b[W-1] ? (~s1_b + W'(1)) : s1_b;
  end

  logic                  s2_valid;
  fpa_pkg::cmd_t         s2_cmd;
  logic [W-1:0]          s2_res;
  logic                  s2_cmp;
  logic signed [2*W-1:0] s2_prod;
  logic [DW-1:0]         s2_num;
  logic [W-1:0]          s2_den;
  logic                  s2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd  <= s1_cmd;
      s2_res  <= s2_res_next;
      s2_cmp  <= s2_cmp_next;
      s2_prod <= prod_next;
      s2_num  <= {mag_a, FRACTION_BITS'(0)};
      s2_den  <= mag_b;
      s2_neg  <= s1_a[W-1] ^ s1_b[W-1];
    end
  end

  // Divider chain: entry 0 takes stage 2 (and finishes the multiply),
  // each later entry resolves one quotient bit
  logic              p_valid [NS+1];
  fpa_pkg::cmd_t     p_cmd   [NS+1];
  logic [W-1:0]      p_res   [NS+1];
  logic              p_cmp   [NS+1];
  logic              p_neg   [NS+1];
  logic [W:0]        p_rem   [NS+1];
  logic [DW-1:0]     p_num   [NS+1];
  logic [DW-1:0]     p_quo   [NS+1];
  logic [W-1:0]      p_den   [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid[0] <= 1'b0;
    end else if (adv) begin
      p_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cmd[0] <= s2_cmd;
      p_res[0] <= (s2_cmd == fpa_pkg::OP_MUL) ? s2_prod[FRACTION_BITS +: W] : s2_res;
      p_cmp[0] <= s2_cmp;
      p_neg[0] <= s2_neg;
      p_rem[0] <= '0;
      p_num[0] <= s2_num;
      p_quo[0] <= '0;
      p_den[0] <= s2_den;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    // shift in next dividend bit, subtract if it fits
    assign trial = {p_rem[k][W-1:0], p_num[k][DW-1]};
    assign diff  = trial - {1'b0, p_den[k]};
    assign fits  = trial >= {1'b0, p_den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        p_valid[k+1] <= 1'b0;
      end else if (adv) begin
        p_valid[k+1] <= p_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p_cmd[k+1] <= p_cmd[k];
        p_res[k+1] <= p_res[k];
        p_cmp[k+1] <= p_cmp[k];
        p_neg[k+1] <= p_neg[k];
        p_den[k+1] <= p_den[k];
        p_rem[k+1] <= fits ? diff : trial;
        p_num[k+1] <= {p_num[k][DW-2:0], 1'b0};
        p_quo[k+1] <= {p_quo[k][DW-2:0], fits};
      end
    end
  end

  // Output register: apply quotient sign and divide-by-zero
  logic [W-1:0] quo_mag;
  logic [W-1:0] div_res;
  logic         div_zero;

  assign quo_mag  = p_quo[NS][W-1:0];
  assign div_res  = p_neg[NS] ? (~quo_mag + W'(1)) : quo_mag;
  assign div_zero = (p_den[NS] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      compare_true <= p_cmp[NS];
      if (p_cmd[NS] == fpa_pkg::OP_DIV) begin
        result_value <= div_zero ? '0 : div_res;
        status       <= div_zero;
      end else begin
        result_value <= p_res[NS];
        status       <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] result_value,
  input logic               compare_true,
  input logic               status
);

  // a held output transaction stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  // divide by zero always reports a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> result_value == 32'sd0)
    else $error("divide by zero with nonzero result");

  // a true comparison never raises the error flag and carries zero value
  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> !status && result_value == 32'sd0)
    else $error("comparison result malformed");

  // input is throttled only by a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .compare_true (compare_true),
  .status       (status)
);

>>> tb/sv/fixed_point_alu_tb.sv
// Testbench for the fixed-point ALU: random and directed transactions checked by a predictor.
`timescale 1ns / 1ps

module fixed_point_alu_tb;

  localparam int FRAC = 8;
  localparam int LATENCY = FRAC + 36;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 750;

  typedef struct packed {
    fpa_pkg::cmd_t  op;
    fpa_pkg::word_t a;
    fpa_pkg::word_t b;
  } alu_req_t;

  typedef struct packed {
    fpa_pkg::word_t value;
    logic           cmp;
    logic           dz;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] cmd = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] result_value;
  logic compare_true;
  logic status;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_for_drain = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  fixed_point_alu #(.FRACTION_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .compare_true(compare_true), .status(status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Compute the ALU result for one operation
  function automatic alu_res_t compute_alu(alu_req_t r);
    alu_res_t o;
    logic signed [31:0] sa, sb;
    logic signed [63:0] prod, dividend, quot;
    sa = r.a;
    sb = r.b;
    o = '0;
    case (r.op)
      fpa_pkg::OP_ADD: o.value = r.a + r.b;
      fpa_pkg::OP_SUB: o.value = r.a - r.b;
      fpa_pkg::OP_MUL: begin
        prod = 64'(sa) * 64'(sb);
        o.value = fpa_pkg::word_t'(prod >>> FRAC);
      end
      fpa_pkg::OP_DIV: begin
        if (sb == 0) begin
          o.dz = 1'b1;
        end else begin
          dividend = 64'(sa) <<< FRAC;
          quot = dividend / 64'(sb);
          o.value = fpa_pkg::word_t'(quot);
        end
      end
      fpa_pkg::OP_INC: o.value = r.a + 32'd1;
      fpa_pkg::OP_DEC: o.value = r.a - 32'd1;
      fpa_pkg::OP_LT: o.cmp = sa < sb;
      fpa_pkg::OP_GT: o.cmp = sa > sb;
      fpa_pkg::OP_EQ: o.cmp = sa == sb;
      fpa_pkg::OP_NE: o.cmp = sa != sb;
      fpa_pkg::OP_GE: o.cmp = sa >= sb;
      fpa_pkg::OP_LE: o.cmp = sa <= sb;
      fpa_pkg::OP_MIN: o.value = (sa > sb) ? r.b : r.a;
      fpa_pkg::OP_MAX: o.value = (sa < sb) ? r.b : r.a;
      fpa_pkg::OP_TO_INT: o.value = fpa_pkg::word_t'(sa >>> FRAC);
      default: o.value = r.a << FRAC;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic fpa_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 512)) - 256);
      3: return {16'($urandom_range(0, 65535)), 16'h0};
      4: return 32'($urandom_range(0, 1)) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_req(fpa_pkg::cmd_t op, fpa_pkg::word_t a, fpa_pkg::word_t b);
    alu_req_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    pending_reqs.push_back(r);
  endtask

  // Stimulus: directed corners, then random transactions
  initial begin
    fpa_pkg::word_t bv;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int op = 0; op < 16; op++)
      push_req(fpa_pkg::cmd_t'(op), 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(fpa_pkg::OP_DIV, 32'h0000_0300, 32'h0);
    push_req(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(fpa_pkg::OP_DIV, 32'hFFFF_FD00, 32'h0000_0200);
    push_req(fpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    push_req(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    push_req(fpa_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678);
    push_req(fpa_pkg::OP_MIN, 32'h5, 32'h5);
    push_req(fpa_pkg::OP_TO_INT, 32'hFFFF_FF01, 32'h0);
    push_req(fpa_pkg::OP_FROM_INT, 32'h00FF_FFFF, 32'hFFFF_FFFF);
    wait (pending_reqs.size() == 0);
    // Let everything drain before the random part
    hold_for_drain = 1'b1;
    wait (expected_results.size() == 0);
    @(posedge clk);
    hold_for_drain = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      bv = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_word();
      if ($urandom_range(0, 3) == 0) bv = rand_word();
      push_req(fpa_pkg::cmd_t'($urandom_range(0, 15)), rand_word(), bv);
    end
    wait (pending_reqs.size() == 0);
    stim_done = 1'b1;
  end

  // Driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) void'(pending_reqs.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_for_drain) begin
        in_valid <= 1'b1;
        cmd <= pending_reqs[0].op;
        operand_a <= pending_reqs[0].a;
        operand_b <= pending_reqs[0].b;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      expected_results.push_back(compute_alu({cmd, operand_a, operand_b}));
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 200;
    if (stall_phase < 60) out_stall <= 1'b0;
    else if (stall_phase < 120) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  // Monitor: compare against the oldest expectation
  always @(posedge clk) begin
    alu_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", result_value, 32'h0);
      end else begin
        e = expected_results.pop_front();
        if (result_value !== e.value) report_mismatch("result_value", result_value, e.value);
        if (compare_true !== e.cmp)
          report_mismatch("compare_true", 32'(compare_true), 32'(e.cmp));
        if (status !== e.dz) report_mismatch("status", 32'(status), 32'(e.dz));
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
